>>> hdl/wls_pkg.sv
// ----------------------------------------------------------------------------
// wls_pkg: shared types and constants of the 2-D wave stencil
// Register map, grid limits and the control word passed between stages.
// ----------------------------------------------------------------------------
package wls_pkg;

  localparam int SIZE_W     = 11;
  localparam int IDX_W      = 10;
  localparam int COEF_REG_W = 16;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int GRID_MAX   = 1024;
  localparam int GRID_MIN   = 3;

  localparam logic [SIZE_W-1:0]     GRID_ROWS_RST = 11'd1024;
  localparam logic [SIZE_W-1:0]     GRID_COLS_RST = 11'd1024;
  localparam logic [COEF_REG_W-1:0] COEF_RST      = 16'd16384;

  typedef enum logic [2:0] {
    REG_GRID_ROWS  = 3'd0,
    REG_GRID_COLS  = 3'd1,
    REG_COEF_X     = 3'd2,
    REG_COEF_Y     = 3'd3,
    REG_FIRST_STEP = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic             valid;
    logic             produce;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } s1_ctl_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] cap);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(GRID_MIN)) begin
      r = SIZE_W'(GRID_MIN);
    end else if (v > cap) begin
      r = cap;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hdl/wave_2d_leapfrog_stencil_top.sv
// ----------------------------------------------------------------------------
// wave_2d_leapfrog_stencil_top: 2-D wave equation five-point stencil
// Streams grid cells in raster order and emits the next value of each
// interior cell, with its row, column and an end-of-frame mark.
//
//   channel   dir  handshake               content
//   s_axis    in   tvalid/tready           tdata: cur_value, prev_value
//                                          tuser: frame_start
//   m_axis    out  tvalid/tready           tdata: next_value, out_row, out_col
//                                          tlast: last
//   apb       in   psel/penable/pready     grid_rows, grid_cols, coef_x,
//                                          coef_y, first_step
//
// One cell per cycle while m_axis keeps up; after its cell is accepted, a result
// passes the line-buffer read, multiply and round/saturate registers.
// The line buffers carry no reset and need no clearing pass; counters,
// taps and valid flags clear on reset.
// A stalled m_axis fills the pipeline, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module wave_2d_leapfrog_stencil_top #(
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 32,
  parameter int COEF_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [VALUE_BITS-1:0] cur_value, [2*VALUE_BITS-1:VALUE_BITS] prev_value, zero pad
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // [0] frame_start
  input  logic                                  s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [VALUE_BITS-1:0] next_value, then out_row (10), out_col (10), zero pad
  output logic [((VALUE_BITS+20+7)/8)*8-1:0]    m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wls_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [wls_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [wls_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  localparam int ColCap = (MAX_COLS < wls_pkg::GRID_MAX) ? MAX_COLS : wls_pkg::GRID_MAX;
  localparam int AddrW  = $clog2(ColCap);
  localparam int OutW   = ((VALUE_BITS + 20 + 7) / 8) * 8;
  localparam int IW     = wls_pkg::IDX_W;

  logic [wls_pkg::SIZE_W-1:0]     grid_rows_q, grid_cols_q;
  logic [wls_pkg::COEF_REG_W-1:0] coef_x_q, coef_y_q;
  logic                           first_step_q;
  wls_pkg::reg_idx_e              reg_idx;

  logic                         accept, s1_adv, s2_ready;
  logic [AddrW-1:0]             rd_addr, s1_addr;
  wls_pkg::s1_ctl_t             s1_ctl;
  logic signed [VALUE_BITS-1:0] s1_cur, above1, above2, prev_dly, next_value;
  logic [IW-1:0]                out_row, out_col;

  assign pready  = 1'b1;
  assign reg_idx = wls_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= wls_pkg::GRID_ROWS_RST;
      grid_cols_q  <= wls_pkg::GRID_COLS_RST;
      coef_x_q     <= wls_pkg::COEF_RST;
      coef_y_q     <= wls_pkg::COEF_RST;
      first_step_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        wls_pkg::REG_GRID_ROWS:  grid_rows_q  <= pwdata[wls_pkg::SIZE_W-1:0];
        wls_pkg::REG_GRID_COLS:  grid_cols_q  <= pwdata[wls_pkg::SIZE_W-1:0];
        wls_pkg::REG_COEF_X:     coef_x_q     <= pwdata[wls_pkg::COEF_REG_W-1:0];
        wls_pkg::REG_COEF_Y:     coef_y_q     <= pwdata[wls_pkg::COEF_REG_W-1:0];
        wls_pkg::REG_FIRST_STEP: first_step_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wls_pkg::REG_GRID_ROWS:  prdata = wls_pkg::APB_DATA_W'(grid_rows_q);
      wls_pkg::REG_GRID_COLS:  prdata = wls_pkg::APB_DATA_W'(grid_cols_q);
      wls_pkg::REG_COEF_X:     prdata = wls_pkg::APB_DATA_W'(coef_x_q);
      wls_pkg::REG_COEF_Y:     prdata = wls_pkg::APB_DATA_W'(coef_y_q);
      wls_pkg::REG_FIRST_STEP: prdata = wls_pkg::APB_DATA_W'(first_step_q);
      default:                 prdata = '0;
    endcase
  end

  wls_ctrl #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .frame_start_i (s_axis_tuser_i),
    .cur_value_i   (s_axis_tdata_i[VALUE_BITS-1:0]),
    .grid_rows_i   (grid_rows_q),
    .grid_cols_i   (grid_cols_q),
    .s2_ready_i    (s2_ready),
    .accept_o      (accept),
    .rd_addr_o     (rd_addr),
    .s1_addr_o     (s1_addr),
    .s1_adv_o      (s1_adv),
    .s1_ctl_o      (s1_ctl),
    .s1_cur_o      (s1_cur)
  );

  wls_linebuf #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_linebuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (accept),
    .addr_i       (rd_addr),
    .cur_value_i  (s_axis_tdata_i[VALUE_BITS-1:0]),
    .prev_value_i (s_axis_tdata_i[2*VALUE_BITS-1:VALUE_BITS]),
    .s1_adv_i     (s1_adv),
    .s1_addr_i    (s1_addr),
    .above1_o     (above1),
    .above2_o     (above2),
    .prev_dly_o   (prev_dly)
  );

  wls_arith #(
    .VALUE_BITS (VALUE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_arith (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_ctl_i     (s1_ctl),
    .s1_cur_i     (s1_cur),
    .above1_i     (above1),
    .above2_i     (above2),
    .prev_dly_i   (prev_dly),
    .coef_x_i     (COEF_BITS'(coef_x_q)),
    .coef_y_i     (COEF_BITS'(coef_y_q)),
    .first_step_i (first_step_q),
    .s2_ready_o   (s2_ready),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .next_value_o (next_value),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutW'({out_col, out_row, next_value});

endmodule

>>> hdl/wls_ctrl.sv
// ----------------------------------------------------------------------------
// wls_ctrl: raster position tracking and first pipeline stage
// Derives row and column of each accepted cell and holds the stage-1 control.
// ----------------------------------------------------------------------------
module wls_ctrl #(
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              frame_start_i,
  input  logic signed [VALUE_BITS-1:0]      cur_value_i,
  input  logic [wls_pkg::SIZE_W-1:0]        grid_rows_i,
  input  logic [wls_pkg::SIZE_W-1:0]        grid_cols_i,
  input  logic                              s2_ready_i,
  output logic                              accept_o,
  output logic [$clog2((MAX_COLS < wls_pkg::GRID_MAX) ? MAX_COLS
                       : wls_pkg::GRID_MAX)-1:0] rd_addr_o,
  output logic [$clog2((MAX_COLS < wls_pkg::GRID_MAX) ? MAX_COLS
                       : wls_pkg::GRID_MAX)-1:0] s1_addr_o,
  output logic                              s1_adv_o,
  output wls_pkg::s1_ctl_t                  s1_ctl_o,
  output logic signed [VALUE_BITS-1:0]      s1_cur_o
);

  localparam int ColCap = (MAX_COLS < wls_pkg::GRID_MAX) ? MAX_COLS : wls_pkg::GRID_MAX;
  localparam int AddrW  = $clog2(ColCap);
  localparam int SW     = wls_pkg::SIZE_W;
  localparam int IW     = wls_pkg::IDX_W;

  logic [SW-1:0] nrows, ncols;
  logic [IW-1:0] row_q, row_d, col_q, col_d;
  logic [IW-1:0] r0, c0, cur_r, cur_c;
  logic [SW-1:0] r1, cn, rn;
  logic          wrap0;
  logic          s1_valid_q, s1_valid_d;
  wls_pkg::s1_ctl_t ctl_q, ctl_d;
  logic [AddrW-1:0] s1_addr_q;
  logic signed [VALUE_BITS-1:0] s1_cur_q;

  assign nrows = wls_pkg::clamp_size(grid_rows_i, SW'(wls_pkg::GRID_MAX));
  assign ncols = wls_pkg::clamp_size(grid_cols_i, SW'(ColCap));

  assign in_ready_o = !s1_valid_q || s2_ready_i;
  assign accept_o   = in_valid_i && in_ready_o;
  assign s1_adv_o   = s1_valid_q && s2_ready_i;

  always_comb begin
    r0    = frame_start_i ? '0 : row_q;
    c0    = frame_start_i ? '0 : col_q;
    wrap0 = {1'b0, c0} >= ncols;
    r1    = wrap0 ? ({1'b0, r0} + SW'(1)) : {1'b0, r0};
    cur_c = wrap0 ? '0 : c0;
    cur_r = (r1 >= nrows) ? '0 : r1[IW-1:0];
    cn    = {1'b0, cur_c} + SW'(1);
    rn    = {1'b0, cur_r} + SW'(1);
    if (cn >= ncols) begin
      col_d = '0;
      row_d = (rn >= nrows) ? '0 : rn[IW-1:0];
    end else begin
      col_d = cn[IW-1:0];
      row_d = cur_r;
    end
    ctl_d.valid   = 1'b1;
    ctl_d.produce = (cur_r >= IW'(2)) && (cur_c >= IW'(2));
    ctl_d.last    = ({1'b0, cur_r} == nrows - SW'(1)) && ({1'b0, cur_c} == ncols - SW'(1));
    ctl_d.row     = cur_r - IW'(1);
    ctl_d.col     = cur_c - IW'(1);
    s1_valid_d    = accept_o ? 1'b1 : (s1_adv_o ? 1'b0 : s1_valid_q);
  end

  assign rd_addr_o = cur_c[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept_o) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      ctl_q     <= ctl_d;
      s1_addr_q <= cur_c[AddrW-1:0];
      s1_cur_q  <= cur_value_i;
    end
  end

  always_comb begin
    s1_ctl_o       = ctl_q;
    s1_ctl_o.valid = s1_valid_q;
  end

  assign s1_addr_o = s1_addr_q;
  assign s1_cur_o  = s1_cur_q;

endmodule

>>> hdl/wls_linebuf.sv
// ----------------------------------------------------------------------------
// wls_linebuf: line buffers for the stencil
// Two rows of current values and one row of previous values, registered reads.
// ----------------------------------------------------------------------------
module wls_linebuf #(
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [$clog2((MAX_COLS < wls_pkg::GRID_MAX) ? MAX_COLS
                       : wls_pkg::GRID_MAX)-1:0] addr_i,
  input  logic signed [VALUE_BITS-1:0] cur_value_i,
  input  logic signed [VALUE_BITS-1:0] prev_value_i,
  input  logic                         s1_adv_i,
  input  logic [$clog2((MAX_COLS < wls_pkg::GRID_MAX) ? MAX_COLS
                       : wls_pkg::GRID_MAX)-1:0] s1_addr_i,
  output logic signed [VALUE_BITS-1:0] above1_o,
  output logic signed [VALUE_BITS-1:0] above2_o,
  output logic signed [VALUE_BITS-1:0] prev_dly_o
);

  localparam int ColCap = (MAX_COLS < wls_pkg::GRID_MAX) ? MAX_COLS : wls_pkg::GRID_MAX;

  logic signed [VALUE_BITS-1:0] row_a_mem [ColCap];
  logic signed [VALUE_BITS-1:0] row_b_mem [ColCap];
  logic signed [VALUE_BITS-1:0] prev_mem  [ColCap];
  logic signed [VALUE_BITS-1:0] rd_a_q, rd_b_q, rd_p_q, byp_data_q;
  logic                         byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_a_mem[addr_i] <= cur_value_i;
      rd_a_q            <= row_a_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      prev_mem[addr_i] <= prev_value_i;
      rd_p_q           <= prev_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_i) begin
      row_b_mem[s1_addr_i] <= rd_a_q;
    end
    if (wr_en_i) begin
      rd_b_q     <= row_b_mem[addr_i];
      byp_data_q <= rd_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (wr_en_i) begin
      byp_q <= s1_adv_i && (s1_addr_i == addr_i);
    end
  end

  assign above1_o   = rd_a_q;
  assign above2_o   = byp_q ? byp_data_q : rd_b_q;
  assign prev_dly_o = rd_p_q;

endmodule

>>> hdl/wls_arith.sv
// ----------------------------------------------------------------------------
// wls_arith: stencil window and update arithmetic
// Holds the window taps, multiplies the Laplacians, rounds and saturates.
// ----------------------------------------------------------------------------
module wls_arith #(
  parameter int VALUE_BITS = 32,
  parameter int COEF_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wls_pkg::s1_ctl_t              s1_ctl_i,
  input  logic signed [VALUE_BITS-1:0]  s1_cur_i,
  input  logic signed [VALUE_BITS-1:0]  above1_i,
  input  logic signed [VALUE_BITS-1:0]  above2_i,
  input  logic signed [VALUE_BITS-1:0]  prev_dly_i,
  input  logic [COEF_BITS-1:0]          coef_x_i,
  input  logic [COEF_BITS-1:0]          coef_y_i,
  input  logic                          first_step_i,
  output logic                          s2_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_BITS-1:0]  next_value_o,
  output logic [wls_pkg::IDX_W-1:0]     out_row_o,
  output logic [wls_pkg::IDX_W-1:0]     out_col_o,
  output logic                          out_last_o
);

  localparam int LW = VALUE_BITS + 2;
  localparam int PW = LW + COEF_BITS + 1;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RndN = SW'(1) <<< (COEF_BITS - 1);
  localparam logic signed [SW-1:0] RndF = SW'(1) <<< COEF_BITS;
  localparam logic signed [SW-1:0] VMax = {{(SW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] VMin = {{(SW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

  logic signed [VALUE_BITS-1:0] win0_q, win1_q, tap_up_q, tap_down_q, tap_prev_q;
  logic signed [LW-1:0] lap_x, lap_y, base, ctr2;
  logic signed [PW-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [LW-1:0] base_q;
  logic                 first_q;
  logic                 s1_adv, s2_take, s3_ready;
  logic                 s2_valid_q, s2_valid_d, out_valid_q, out_valid_d;
  logic [wls_pkg::IDX_W-1:0] s2_row_q, s2_col_q;
  logic                 s2_last_q;
  logic signed [SW-1:0] sum, rounded, res;
  logic signed [VALUE_BITS-1:0] sat;
  logic signed [VALUE_BITS-1:0] next_value_q;
  logic [wls_pkg::IDX_W-1:0] out_row_q, out_col_q;
  logic                 out_last_q;

  assign s3_ready   = !out_valid_q || out_ready_i;
  assign s2_ready_o = !s2_valid_q || s3_ready;
  assign s1_adv     = s1_ctl_i.valid && s2_ready_o;
  assign s2_take    = s2_valid_q && s3_ready;

  always_comb begin
    ctr2     = LW'(win0_q) <<< 1;
    lap_x    = LW'(tap_up_q) + LW'(tap_down_q) - ctr2;
    lap_y    = LW'(win1_q) + LW'(above1_i) - ctr2;
    base     = first_step_i ? LW'(win0_q) : (ctr2 - LW'(tap_prev_q));
    prod_x_d = $signed({1'b0, coef_x_i}) * lap_x;
    prod_y_d = $signed({1'b0, coef_y_i}) * lap_y;
    s2_valid_d  = (s1_adv && s1_ctl_i.produce) ? 1'b1 : (s2_take ? 1'b0 : s2_valid_q);
    out_valid_d = s2_take ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_comb begin
    sum     = SW'(prod_x_q) + SW'(prod_y_q);
    rounded = first_q ? ((sum + RndF) >>> (COEF_BITS + 1)) : ((sum + RndN) >>> COEF_BITS);
    res     = rounded + SW'(base_q);
    if (res > VMax) begin
      sat = VMax[VALUE_BITS-1:0];
    end else if (res < VMin) begin
      sat = VMin[VALUE_BITS-1:0];
    end else begin
      sat = res[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q      <= '0;
      win1_q      <= '0;
      tap_up_q    <= '0;
      tap_down_q  <= '0;
      tap_prev_q  <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        win1_q     <= win0_q;
        win0_q     <= above1_i;
        tap_up_q   <= above2_i;
        tap_down_q <= s1_cur_i;
        tap_prev_q <= prev_dly_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_ctl_i.produce) begin
      prod_x_q  <= prod_x_d;
      prod_y_q  <= prod_y_d;
      base_q    <= base;
      first_q   <= first_step_i;
      s2_row_q  <= s1_ctl_i.row;
      s2_col_q  <= s1_ctl_i.col;
      s2_last_q <= s1_ctl_i.last;
    end
    if (s2_take) begin
      next_value_q <= sat;
      out_row_q    <= s2_row_q;
      out_col_q    <= s2_col_q;
      out_last_q   <= s2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_value_o = next_value_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_last_o   = out_last_q;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: wave_2d_leapfrog_stencil_top
// Streams raster-ordered grid cells with random idle gaps on both buses,
// predicts every interior-cell update (normal and first-step leapfrog,
// rounding, saturation, counter wrap and size clamping) and checks each
// result on m_axis in order. The register setup changes between phases over
// APB: clamped grid sizes, extreme coefficients and a mid-frame resize.
// One long output stall backs the pipeline up into s_axis.
// ----------------------------------------------------------------------------
module testbench;

  localparam int           VAL_W        = 32;
  localparam int           COEF_W       = 16;
  localparam int           IN_W         = ((2 * VAL_W + 7) / 8) * 8;
  localparam int           OUT_W        = ((VAL_W + 20 + 7) / 8) * 8;
  localparam longint       VALUE_MAX    = 64'sd2147483647;
  localparam longint       VALUE_MIN    = -64'sd2147483648;
  localparam longint       HALF_LSB     = 64'sd32768;
  localparam longint       HALF_LSB_FS  = 64'sd65536;
  localparam int unsigned  RANDOM_SITES = 600;
  localparam int unsigned  HOLD_CYCLES  = 300;
  localparam int unsigned  SETTLE_WAIT  = 12;
  localparam int unsigned  QUIET_LIMIT  = 2000;

  localparam logic [31:0] EDGE_VALS [16] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0800_0000, 32'hF800_0000, 32'h7FFF_FFFE,
    32'h8000_0001, 32'h4000_0000, 32'hC000_0000, 32'h0000_8000,
    32'hFFFF_8000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002
  };

  typedef struct packed {
    logic        fs;
    logic [31:0] prv;
    logic [31:0] cur;
  } site_t;

  typedef struct packed {
    logic                      last;
    logic [wls_pkg::IDX_W-1:0] col;
    logic [wls_pkg::IDX_W-1:0] row;
    logic [VAL_W-1:0]          value;
  } stencil_out_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [wls_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [wls_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [wls_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  site_t        site_q [$];
  stencil_out_t next_q [$];

  logic        in_taken = 1'b0;
  logic        gaps_on = 1'b1;
  int unsigned feed_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_given = 0;
  int unsigned quiet = 0;
  int unsigned errors = 0;
  int unsigned queued_sites = 0;
  int unsigned sites_taken = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_phases = 0;

  // stencil state
  logic [wls_pkg::SIZE_W-1:0]     cfg_rows = wls_pkg::GRID_ROWS_RST;
  logic [wls_pkg::SIZE_W-1:0]     cfg_cols = wls_pkg::GRID_COLS_RST;
  logic [wls_pkg::COEF_REG_W-1:0] cfg_kx = wls_pkg::COEF_RST;
  logic [wls_pkg::COEF_REG_W-1:0] cfg_ky = wls_pkg::COEF_RST;
  logic                           cfg_first = 1'b0;
  longint      line_near [wls_pkg::GRID_MAX] = '{default: 0};
  longint      line_far  [wls_pkg::GRID_MAX] = '{default: 0};
  longint      prev_line [wls_pkg::GRID_MAX] = '{default: 0};
  longint      win [3] = '{default: 0};
  longint      tap_up = 0;
  longint      tap_down = 0;
  longint      tap_prev = 0;
  int unsigned row_at = 0;
  int unsigned col_at = 0;

  wave_2d_leapfrog_stencil_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    // [31:0] cur_value, [63:32] prev_value
    .s_axis_tdata_i  (s_axis_tdata),
    // [0] frame_start
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    // [31:0] next_value, [41:32] out_row, [51:42] out_col, zero pad
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [wls_pkg::SIZE_W-1:0] v);
    if (v < wls_pkg::GRID_MIN) return wls_pkg::GRID_MIN;
    if (v > wls_pkg::GRID_MAX) return wls_pkg::GRID_MAX;
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 25);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(99);
    v = $urandom;
    if (r < 60) return {{5{v[26]}}, v[26:0]};
    if (r < 85) return v;
    return EDGE_VALS[$urandom_range(15)];
  endfunction

  function automatic logic [31:0] pick_coef();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 32'd0;
    if (r < 30) return 32'd65535;
    return $urandom;
  endfunction

  function automatic logic [wls_pkg::SIZE_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return wls_pkg::SIZE_W'($urandom_range(2));
    if (r < 20) return wls_pkg::SIZE_W'(wls_pkg::GRID_MIN);
    return wls_pkg::SIZE_W'($urandom_range(14, 4));
  endfunction

  // advance the stencil by one cell and queue the interior result it yields
  task automatic predict_site(input logic [31:0] cur, input logic [31:0] prv,
                              input logic fs);
    int unsigned  nr, nc;
    longint       u, a1, a2, pd, ctr, lapx, lapy, acc, nxt;
    stencil_out_t want;
    nr = clamp_dim(cfg_rows);
    nc = clamp_dim(cfg_cols);
    u  = longint'($signed(cur));
    if (fs) begin
      row_at = 0;
      col_at = 0;
    end
    if (col_at >= nc) begin
      col_at = 0;
      row_at++;
    end
    if (row_at >= nr) row_at = 0;
    a1 = line_near[col_at];
    a2 = line_far[col_at];
    pd = prev_line[col_at];
    line_far[col_at]  = a1;
    line_near[col_at] = u;
    prev_line[col_at] = longint'($signed(prv));
    win[2] = win[1];
    win[1] = win[0];
    win[0] = a1;
    if (row_at >= 2 && col_at >= 2) begin
      ctr  = win[1];
      lapx = tap_up + tap_down - 2 * ctr;
      lapy = win[2] + win[0] - 2 * ctr;
      acc  = longint'(cfg_kx) * lapx + longint'(cfg_ky) * lapy;
      if (cfg_first) begin
        nxt = ctr + ((acc + HALF_LSB_FS) >>> (COEF_W + 1));
      end else begin
        nxt = 2 * ctr - tap_prev + ((acc + HALF_LSB) >>> COEF_W);
      end
      if (nxt > VALUE_MAX) nxt = VALUE_MAX;
      if (nxt < VALUE_MIN) nxt = VALUE_MIN;
      want.value = nxt[VAL_W-1:0];
      want.row   = wls_pkg::IDX_W'(row_at - 1);
      want.col   = wls_pkg::IDX_W'(col_at - 1);
      want.last  = (row_at == nr - 1) && (col_at == nc - 1);
      next_q.push_back(want);
    end
    tap_up   = a2;
    tap_down = u;
    tap_prev = pd;
    col_at++;
    if (col_at >= nc) begin
      col_at = 0;
      row_at++;
      if (row_at >= nr) row_at = 0;
    end
  endtask

  always @(negedge clk) begin : feed_sites
    site_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (feed_gap > 0) begin
        feed_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (site_q.size() > 0) begin
        nxt = site_q.pop_front();
        s_axis_tdata  <= {nxt.prv, nxt.cur};
        s_axis_tuser  <= nxt.fs;
        s_axis_tvalid <= 1'b1;
        feed_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : take_results
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : watch_ports
    stencil_out_t got, want;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_site(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tuser);
        sites_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got = {m_axis_tlast, m_axis_tdata[VAL_W+2*wls_pkg::IDX_W-1:0]};
        if (next_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %h row %0d col %0d last %0b",
                   $time, got.value, got.row, got.col, got.last);
        end else begin
          want = next_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected value %h row %0d col %0d last %0b",
                     $time, want.value, want.row, want.col, want.last);
            $display("%0t:          actual   value %h row %0d col %0d last %0b",
                     $time, got.value, got.row, got.col, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, quiet);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input wls_pkg::reg_idx_e idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wls_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      wls_pkg::REG_GRID_ROWS:  cfg_rows  = data[wls_pkg::SIZE_W-1:0];
      wls_pkg::REG_GRID_COLS:  cfg_cols  = data[wls_pkg::SIZE_W-1:0];
      wls_pkg::REG_COEF_X:     cfg_kx    = data[wls_pkg::COEF_REG_W-1:0];
      wls_pkg::REG_COEF_Y:     cfg_ky    = data[wls_pkg::COEF_REG_W-1:0];
      wls_pkg::REG_FIRST_STEP: cfg_first = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] rows, input logic [31:0] cols,
                           input logic [31:0] kx, input logic [31:0] ky,
                           input logic [31:0] first);
    write_reg(wls_pkg::REG_GRID_ROWS, rows);
    write_reg(wls_pkg::REG_GRID_COLS, cols);
    write_reg(wls_pkg::REG_COEF_X, kx);
    write_reg(wls_pkg::REG_COEF_Y, ky);
    write_reg(wls_pkg::REG_FIRST_STEP, first);
    cfg_phases++;
  endtask

  task automatic push_run(input int unsigned count, input logic fs_first,
                          input logic noisy);
    site_t s;
    for (int unsigned i = 0; i < count; i++) begin
      s.cur = pick_value();
      s.prv = pick_value();
      s.fs  = (i == 0) ? fs_first : (noisy && $urandom_range(199) == 0);
      site_q.push_back(s);
      queued_sites++;
    end
  endtask

  // wait until every request is taken and every result is back, then let
  // boundary cells still in the pipeline flush out
  task automatic settle();
    @(posedge clk);
    while (site_q.size() != 0 || s_axis_tvalid || next_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  initial begin : stimulus
    site_t                      s;
    logic [wls_pkg::SIZE_W-1:0] rows_raw, cols_raw;
    int unsigned                nr, nc, nf, target;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // full-scale coefficients on edge values, then first-step on a 3x3 grid
    configure(4, 4, 65535, 65535, 0);
    for (int i = 0; i < 16; i++) begin
      s.cur = EDGE_VALS[i];
      s.prv = EDGE_VALS[15 - i];
      s.fs  = (i == 0);
      site_q.push_back(s);
      queued_sites++;
    end
    settle();
    configure(3, 3, 0, 65535, 1);
    for (int i = 0; i < 9; i++) begin
      s.cur = EDGE_VALS[(i * 5) % 16];
      s.prv = EDGE_VALS[(i * 3 + 1) % 16];
      s.fs  = (i == 0);
      site_q.push_back(s);
      queued_sites++;
    end
    settle();

    // shrink width, then height, in the middle of a frame
    configure(6, 8, pick_coef(), pick_coef(), 0);
    push_run(30, 1'b1, 1'b0);
    settle();
    write_reg(wls_pkg::REG_GRID_COLS, 4);
    push_run(6, 1'b0, 1'b0);
    settle();
    write_reg(wls_pkg::REG_GRID_ROWS, 4);
    push_run(14, 1'b0, 1'b0);
    settle();

    // long output stall with the input side kept busy
    configure(12, 12, pick_coef(), pick_coef(), 0);
    gaps_on = 1'b0;
    push_run(144, 1'b1, 1'b0);
    hold_asked++;
    settle();

    // clamped register values: a tall grid cut short, then two 3x3 frames, only the first marked
    gaps_on = 1'b1;
    configure(2047, 2, pick_coef(), pick_coef(), $urandom_range(1));
    push_run(20 * wls_pkg::GRID_MIN, 1'b1, 1'b0);
    settle();
    configure(1, 0, pick_coef(), pick_coef(), $urandom_range(1));
    push_run(2 * wls_pkg::GRID_MIN * wls_pkg::GRID_MIN, 1'b1, 1'b0);
    settle();

    target = queued_sites + RANDOM_SITES;
    while (queued_sites < target) begin
      rows_raw = pick_dim();
      cols_raw = pick_dim();
      configure(rows_raw, cols_raw, pick_coef(), pick_coef(), $urandom_range(1));
      gaps_on = ($urandom_range(3) != 0);
      nr = clamp_dim(rows_raw);
      nc = clamp_dim(cols_raw);
      if ($urandom_range(6) == 0) push_run($urandom_range(nr * nc - 1, 1), 1'b1, 1'b1);
      nf = $urandom_range(3, 1);
      for (int unsigned f = 0; f < nf; f++) begin
        push_run(nr * nc, (f == 0) || ($urandom_range(1) == 1), 1'b1);
      end
      settle();
    end

    repeat (SETTLE_WAIT) @(posedge clk);
    if (next_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, next_q.size());
    end
    $display("%0d cells sent, %0d interior results checked over %0d register setups",
             sites_taken, results_seen, cfg_phases);
    $display("covered: clamped grid sizes, first-step, mid-frame resize, long output stall");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/wls_pkg.sv
hdl/wls_ctrl.sv
hdl/wls_linebuf.sv
hdl/wls_arith.sv
hdl/wave_2d_leapfrog_stencil_top.sv
sim/testbench.sv
